[design/sthit_pkg.sv]
// ----------------------------------------------------------------------------
// Shape table hit test package
// Shared sizes, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sthit_pkg;

   localparam int MaxShapes = 16;
   localparam int MaxPoints = 256;
   localparam int CoordBits = 16;
   localparam int LabelBits = 32;

   localparam int ShapeIdxW = $clog2(MaxShapes);
   localparam int ShapeCntW = $clog2(MaxShapes + 1);
   localparam int PointIdxW = $clog2(MaxPoints);
   localparam int PointCntW = $clog2(MaxPoints + 1);
   localparam int PointW    = 2 * CoordBits;
   localparam int DiffW     = CoordBits + 1;
   // A squared difference must fit as a positive multiplier operand.
   localparam int MulOpW    = 2 * CoordBits + 1;
   localparam int ProdW     = 4 * CoordBits;
   localparam int NumProd   = 7;
   localparam int StepW     = $clog2(NumProd);

   localparam logic [2:0] KindRect     = 3'd0;
   localparam logic [2:0] KindCircle   = 3'd1;
   localparam logic [2:0] KindEllipse  = 3'd2;
   localparam logic [2:0] KindTriangle = 3'd3;
   localparam logic [2:0] KindPolygon  = 3'd4;

   localparam logic [1:0] StatusOk         = 2'd0;
   localparam logic [1:0] StatusShapesFull = 2'd1;
   localparam logic [1:0] StatusPointsFull = 2'd2;
   localparam logic [1:0] StatusNoShape    = 2'd3;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_OPEN   = 2'd1,
      CMD_APPEND = 2'd2,
      CMD_PICK   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHAPE,
      ST_LD0,
      ST_LD1,
      ST_LD2,
      ST_CALC,
      ST_EVAL,
      ST_PB,
      ST_PWB,
      ST_PWA,
      ST_PEDGE,
      ST_PRD,
      ST_HIT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RD_OFF0,
      RD_OFF1,
      RD_OFF2,
      RD_LAST,
      RD_EDGE
   } rd_sel_type;

   typedef enum logic [1:0] {
      LD_NONE,
      LD_V0,
      LD_V1,
      LD_V2
   } ld_sel_type;

   typedef struct packed {
      logic             req_take;
      logic             shape_clr;
      logic             shape_inc;
      logic             rd_en;
      rd_sel_type       rd_sel;
      ld_sel_type       ld_sel;
      logic             mul_en;
      logic [StepW-1:0] step;
      logic             edge_clr;
      logic             edge_step;
      logic             res_load;
      logic             res_hit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       shape_end;
      logic [2:0] kind;
      logic       poly_short;
      logic       verdict;
      logic       edge_last;
      logic       out_free;
   } dp_stat_type;

   // Number of products each kind needs before its verdict, or per edge for a polygon.
   function automatic logic [StepW-1:0] steps_for_kind(input logic [2:0] kind);
      logic [StepW-1:0] n;
      case (kind)
         KindCircle:   n = StepW'(3);
         KindEllipse:  n = StepW'(7);
         KindTriangle: n = StepW'(6);
         KindPolygon:  n = StepW'(2);
         default:      n = '0;
      endcase
      return n;
   endfunction

endpackage

[design/shape_table_hit_test_unit.sv]
// Clear, open and append pass from the idle state through the done state to the result beat.
// Pick walks the shapes in table order until one hits, loading each shape's first three
// points through the point store read port and forming its products one at a time on the
// shared multiplier; a polygon is then walked edge by edge. One request is in flight at a
// time; a new request beat is taken while the previous result beat still waits.
// Synchronous reset empties the shape table and point store and drops rsp_valid.
// ----------------------------------------------------------------------------
// Shape table hit test unit
// Ordered shape table with exact point-in-shape pick.
// ----------------------------------------------------------------------------
module shape_table_hit_test_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_command,
   input  logic [2:0]                              req_shape_kind,
   input  logic [sthit_pkg::LabelBits-1:0]         req_shape_label,
   input  logic signed [sthit_pkg::CoordBits-1:0]  req_x_coord,
   input  logic signed [sthit_pkg::CoordBits-1:0]  req_y_coord,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [sthit_pkg::LabelBits-1:0]         rsp_hit_label,
   output logic [1:0]                              rsp_status
);
   import sthit_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   sthit_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd)
   );

   sthit_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_shape_kind  (req_shape_kind),
      .req_shape_label (req_shape_label),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_hit_label   (rsp_hit_label),
      .rsp_status      (rsp_status)
   );

endmodule

[design/sthit_ctrl.sv]
// ----------------------------------------------------------------------------
// Shape table hit test controller
// Sequences table commands and the pick walk over shapes and polygon edges.
// ----------------------------------------------------------------------------
module sthit_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  sthit_pkg::dp_stat_type  stat,
   output sthit_pkg::ctrl_cmd_type cmd
);
   import sthit_pkg::*;

   state_type        state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [StepW-1:0] nsteps;

   assign nsteps = steps_for_kind(stat.kind);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_OFF0;
      cmd.ld_sel = LD_NONE;
      cmd.step   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               if (cmd_type'(req_command) == CMD_PICK) begin
                  cmd.shape_clr = 1'b1;
                  state_in      = ST_SHAPE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHAPE: begin
            if (stat.shape_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_OFF0;
               state_in   = ST_LD0;
            end
         end
         ST_LD0: begin
            cmd.ld_sel = LD_V0;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_OFF1;
            state_in   = ST_LD1;
         end
         ST_LD1: begin
            cmd.ld_sel = LD_V1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_OFF2;
            state_in   = ST_LD2;
         end
         ST_LD2: begin
            cmd.ld_sel = LD_V2;
            step_in    = '0;
            if (stat.kind == KindPolygon) begin
               state_in = stat.poly_short ? ST_EVAL : ST_PB;
            end else if (nsteps == '0) begin
               state_in = ST_EVAL;
            end else begin
               state_in = ST_CALC;
            end
         end
         ST_PB: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_LAST;
            cmd.edge_clr = 1'b1;
            state_in     = ST_PWB;
         end
         ST_PWB: begin
            cmd.ld_sel = LD_V1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_EDGE;
            state_in   = ST_PWA;
         end
         ST_PWA: begin
            cmd.ld_sel = LD_V0;
            step_in    = '0;
            state_in   = ST_CALC;
         end
         ST_CALC: begin
            cmd.mul_en = 1'b1;
            if (step_ff == nsteps - StepW'(1)) begin
               state_in = (stat.kind == KindPolygon) ? ST_PEDGE : ST_EVAL;
            end else begin
               step_in = step_ff + StepW'(1);
            end
         end
         ST_PEDGE: begin
            cmd.edge_step = 1'b1;
            state_in      = stat.edge_last ? ST_EVAL : ST_PRD;
         end
         ST_PRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_EDGE;
            state_in   = ST_PWA;
         end
         ST_EVAL: begin
            if (stat.verdict) begin
               state_in = ST_HIT;
            end else begin
               cmd.shape_inc = 1'b1;
               state_in      = ST_SHAPE;
            end
         end
         ST_HIT: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               cmd.res_hit  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[design/sthit_dp.sv]
// ----------------------------------------------------------------------------
// Shape table hit test datapath
// Shape tables, point store, shared multiplier, shape tests and result beat.
// ----------------------------------------------------------------------------
module sthit_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sthit_pkg::ctrl_cmd_type               cmd,
   output sthit_pkg::dp_stat_type                stat,
   input  logic [1:0]                            req_command,
   input  logic [2:0]                            req_shape_kind,
   input  logic [sthit_pkg::LabelBits-1:0]       req_shape_label,
   input  logic signed [sthit_pkg::CoordBits-1:0] req_x_coord,
   input  logic signed [sthit_pkg::CoordBits-1:0] req_y_coord,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [sthit_pkg::LabelBits-1:0]       rsp_hit_label,
   output logic [1:0]                            rsp_status
);
   import sthit_pkg::*;

   // Tables and point store
   logic [2:0]           kind_tab  [MaxShapes];
   logic [LabelBits-1:0] label_tab [MaxShapes];
   logic [PointCntW-1:0] first_tab [MaxShapes];
   logic [PointCntW-1:0] count_tab [MaxShapes];
   logic [PointW-1:0]    point_mem [MaxPoints];

   logic [ShapeCntW-1:0] shapes_used_ff;
   logic [PointCntW-1:0] points_used_ff;
   logic                 rsp_valid_ff;

   logic [ShapeCntW-1:0] s_ff;
   logic [1:0]           status_ff;
   logic signed [CoordBits-1:0] px_ff, py_ff;
   logic signed [CoordBits-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic [PointW-1:0]    rd_data_ff;
   logic                 oob_ff;
   logic signed [ProdW-1:0] r_ff [NumProd];
   logic [PointCntW-1:0] i_ff;
   logic                 odd_ff;
   logic [LabelBits-1:0] rsp_hit_ff;
   logic [1:0]           rsp_status_ff;

   logic                 shapes_full, no_shape, points_full, append_ok;
   logic [1:0]           status_new;
   logic [ShapeIdxW-1:0] s_idx, last_idx, new_idx;
   logic [2:0]           kind_cur;
   logic [PointCntW-1:0] base_cur, n_cur, off;
   logic [PointCntW:0]   addr_sum;
   logic                 oob;
   logic signed [CoordBits-1:0] ld_x, ld_y;

   assign shapes_full = shapes_used_ff >= ShapeCntW'(MaxShapes);
   assign no_shape    = shapes_used_ff == '0;
   assign points_full = points_used_ff >= PointCntW'(MaxPoints);
   assign append_ok   = !no_shape && !points_full;
   assign new_idx     = shapes_used_ff[ShapeIdxW-1:0];
   assign last_idx    = ShapeIdxW'(shapes_used_ff - ShapeCntW'(1));

   always_comb begin
      case (cmd_type'(req_command))
         CMD_OPEN:   status_new = shapes_full ? StatusShapesFull : StatusOk;
         CMD_APPEND: status_new = no_shape ? StatusNoShape :
                                  (points_full ? StatusPointsFull : StatusOk);
         default:    status_new = StatusOk;
      endcase
   end

   assign s_idx    = s_ff[ShapeIdxW-1:0];
   assign kind_cur = kind_tab[s_idx];
   assign base_cur = first_tab[s_idx];
   assign n_cur    = count_tab[s_idx];

   always_comb begin
      case (cmd.rd_sel)
         RD_OFF1: off = PointCntW'(1);
         RD_OFF2: off = PointCntW'(2);
         RD_LAST: off = n_cur - PointCntW'(1);
         RD_EDGE: off = i_ff;
         default: off = '0;
      endcase
   end

   // Points past the end of the store read as the origin.
   assign addr_sum = {1'b0, base_cur} + {1'b0, off};
   assign oob      = addr_sum >= (PointCntW + 1)'(MaxPoints);
   assign ld_x     = oob_ff ? '0 : $signed(rd_data_ff[PointW-1:CoordBits]);
   assign ld_y     = oob_ff ? '0 : $signed(rd_data_ff[CoordBits-1:0]);

   // Differences and end sums used by the shape tests
   logic signed [DiffW-1:0] dx0, dy0, dx2, dy2, t_a, t_b, t_c, t_e, t_f;
   logic signed [DiffW-1:0] e_py, e_bx, e_px, e_by, x_end, y_end;
   assign dx0  = DiffW'(px_ff) - DiffW'(v0x_ff);
   assign dy0  = DiffW'(py_ff) - DiffW'(v0y_ff);
   assign dx2  = DiffW'(px_ff) - DiffW'(v2x_ff);
   assign dy2  = DiffW'(py_ff) - DiffW'(v2y_ff);
   assign t_a  = DiffW'(v1y_ff) - DiffW'(v2y_ff);
   assign t_b  = DiffW'(v2x_ff) - DiffW'(v1x_ff);
   assign t_c  = DiffW'(v0x_ff) - DiffW'(v2x_ff);
   assign t_e  = DiffW'(v0y_ff) - DiffW'(v2y_ff);
   assign t_f  = DiffW'(v2y_ff) - DiffW'(v0y_ff);
   assign e_py = dy0;
   assign e_px = dx0;
   assign e_bx = DiffW'(v1x_ff) - DiffW'(v0x_ff);
   assign e_by = DiffW'(v1y_ff) - DiffW'(v0y_ff);
   assign x_end = DiffW'(v0x_ff) + DiffW'(v1x_ff);
   assign y_end = DiffW'(v0y_ff) + DiffW'(v1y_ff);

   // Shared multiplier: operands chosen by kind and step.
   logic signed [MulOpW-1:0]   mul_a, mul_b;
   logic signed [2*MulOpW-1:0] prod_full;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (kind_cur)
         KindCircle: begin
            case (cmd.step)
               StepW'(0): begin mul_a = MulOpW'(dx0); mul_b = MulOpW'(dx0); end
               StepW'(1): begin mul_a = MulOpW'(dy0); mul_b = MulOpW'(dy0); end
               default:   begin mul_a = MulOpW'(v1x_ff); mul_b = MulOpW'(v1x_ff); end
            endcase
         end
         KindEllipse: begin
            case (cmd.step)
               StepW'(0): begin mul_a = MulOpW'(dx0); mul_b = MulOpW'(dx0); end
               StepW'(1): begin mul_a = MulOpW'(dy0); mul_b = MulOpW'(dy0); end
               StepW'(2): begin mul_a = MulOpW'(v1x_ff); mul_b = MulOpW'(v1x_ff); end
               StepW'(3): begin mul_a = MulOpW'(v1y_ff); mul_b = MulOpW'(v1y_ff); end
               StepW'(4): begin mul_a = MulOpW'(r_ff[0]); mul_b = MulOpW'(r_ff[3]); end
               StepW'(5): begin mul_a = MulOpW'(r_ff[1]); mul_b = MulOpW'(r_ff[2]); end
               default:   begin mul_a = MulOpW'(r_ff[2]); mul_b = MulOpW'(r_ff[3]); end
            endcase
         end
         KindTriangle: begin
            case (cmd.step)
               StepW'(0): begin mul_a = MulOpW'(t_a); mul_b = MulOpW'(t_c); end
               StepW'(1): begin mul_a = MulOpW'(t_b); mul_b = MulOpW'(t_e); end
               StepW'(2): begin mul_a = MulOpW'(t_a); mul_b = MulOpW'(dx2); end
               StepW'(3): begin mul_a = MulOpW'(t_b); mul_b = MulOpW'(dy2); end
               StepW'(4): begin mul_a = MulOpW'(t_f); mul_b = MulOpW'(dx2); end
               default:   begin mul_a = MulOpW'(t_c); mul_b = MulOpW'(dy2); end
            endcase
         end
         KindPolygon: begin
            case (cmd.step)
               StepW'(0): begin mul_a = MulOpW'(e_py); mul_b = MulOpW'(e_bx); end
               default:   begin mul_a = MulOpW'(e_px); mul_b = MulOpW'(e_by); end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;

   // Shape verdicts
   logic rect_hit, circle_hit, ellipse_hit, tri_hit, edge_cross;
   logic signed [ProdW-1:0] t_d, t_sv, t_tv, t_sum;
   logic [ProdW:0]          e_lhs;

   assign rect_hit = (n_cur >= PointCntW'(2)) &&
                     (px_ff >= v0x_ff) && (DiffW'(px_ff) < x_end) &&
                     (py_ff >= v0y_ff) && (DiffW'(py_ff) < y_end);
   assign circle_hit = (n_cur >= PointCntW'(2)) && (v1x_ff > 0) &&
                       (r_ff[0] + r_ff[1] <= r_ff[2]);
   assign e_lhs = {1'b0, r_ff[4]} + {1'b0, r_ff[5]};
   assign ellipse_hit = (n_cur >= PointCntW'(2)) && (v1x_ff != 0) && (v1y_ff != 0) &&
                        (e_lhs <= {1'b0, r_ff[6]});
   assign t_d   = r_ff[0] + r_ff[1];
   assign t_sv  = r_ff[2] + r_ff[3];
   assign t_tv  = r_ff[4] + r_ff[5];
   assign t_sum = t_sv + t_tv;
   always_comb begin
      if (t_d < 0) begin
         tri_hit = (t_sv <= 0) && (t_tv <= 0) && (t_sum >= t_d);
      end else begin
         tri_hit = (t_sv >= 0) && (t_tv >= 0) && (t_sum <= t_d);
      end
      tri_hit = tri_hit && (n_cur >= PointCntW'(3));
   end

   // Edge a = v0 (current vertex), b = v1 (previous vertex).
   always_comb begin
      edge_cross = ((v0y_ff < py_ff && v1y_ff >= py_ff) ||
                    (v1y_ff < py_ff && v0y_ff >= py_ff)) &&
                   (v0x_ff <= px_ff || v1x_ff <= px_ff);
      if (e_by > 0) begin
         edge_cross = edge_cross && (r_ff[0] < r_ff[1]);
      end else begin
         edge_cross = edge_cross && (r_ff[0] > r_ff[1]);
      end
   end

   always_comb begin
      stat            = '0;
      stat.shape_end  = s_ff >= shapes_used_ff;
      stat.kind       = kind_cur;
      stat.poly_short = n_cur < PointCntW'(3);
      stat.edge_last  = i_ff == n_cur - PointCntW'(1);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      case (kind_cur)
         KindRect:     stat.verdict = rect_hit;
         KindCircle:   stat.verdict = circle_hit;
         KindEllipse:  stat.verdict = ellipse_hit;
         KindTriangle: stat.verdict = tri_hit;
         KindPolygon:  stat.verdict = odd_ff && (n_cur >= PointCntW'(3));
         default:      stat.verdict = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shapes_used_ff <= '0;
         points_used_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.req_take) begin
            case (cmd_type'(req_command))
               CMD_CLEAR: begin
                  shapes_used_ff <= '0;
                  points_used_ff <= '0;
               end
               CMD_OPEN: begin
                  if (!shapes_full) begin
                     shapes_used_ff <= shapes_used_ff + ShapeCntW'(1);
                  end
               end
               CMD_APPEND: begin
                  if (append_ok) begin
                     points_used_ff <= points_used_ff + PointCntW'(1);
                  end
               end
               default: ;
            endcase
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers and storage
   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         status_ff <= status_new;
         case (cmd_type'(req_command))
            CMD_OPEN: begin
               if (!shapes_full) begin
                  kind_tab[new_idx]  <= req_shape_kind;
                  label_tab[new_idx] <= req_shape_label;
                  first_tab[new_idx] <= points_used_ff;
                  count_tab[new_idx] <= '0;
               end
            end
            CMD_APPEND: begin
               if (append_ok) begin
                  point_mem[points_used_ff[PointIdxW-1:0]] <= {req_x_coord, req_y_coord};
                  count_tab[last_idx] <= count_tab[last_idx] + PointCntW'(1);
               end
            end
            CMD_PICK: begin
               px_ff <= req_x_coord;
               py_ff <= req_y_coord;
            end
            default: ;
         endcase
      end
      if (cmd.rd_en) begin
         rd_data_ff <= point_mem[addr_sum[PointIdxW-1:0]];
         oob_ff     <= oob;
      end
      if (cmd.shape_clr) begin
         s_ff <= '0;
      end else if (cmd.shape_inc) begin
         s_ff <= s_ff + ShapeCntW'(1);
      end
      case (cmd.ld_sel)
         LD_V0: begin v0x_ff <= ld_x; v0y_ff <= ld_y; end
         LD_V1: begin v1x_ff <= ld_x; v1y_ff <= ld_y; end
         LD_V2: begin v2x_ff <= ld_x; v2y_ff <= ld_y; end
         default: ;
      endcase
      if (cmd.mul_en) begin
         r_ff[cmd.step] <= $signed(prod_full[ProdW-1:0]);
      end
      if (cmd.edge_clr) begin
         i_ff   <= '0;
         odd_ff <= 1'b0;
      end else if (cmd.edge_step) begin
         odd_ff <= odd_ff ^ edge_cross;
         v1x_ff <= v0x_ff;
         v1y_ff <= v0y_ff;
         i_ff   <= i_ff + PointCntW'(1);
      end
      if (cmd.res_load) begin
         rsp_hit_ff    <= cmd.res_hit ? label_tab[s_idx] : '0;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_label = rsp_hit_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Shape table hit test unit testbench
// Builds shape tables through the request channel and checks the result of
// every beat against a predictor kept in step with each accepted request.
// It covers directed corner cases, table and point store limits, random
// scenes with picks, and a long stall on the result channel.
// ----------------------------------------------------------------------------
module tb_top;
   import sthit_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] KindUndef = 3'd6;
   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles   = 2000;

   typedef struct {
      logic [LabelBits-1:0] hit_label;
      logic [1:0]           status;
   } pick_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_command = CMD_CLEAR;
   logic [2:0]                  req_shape_kind = KindRect;
   logic [LabelBits-1:0]        req_shape_label = '0;
   logic signed [CoordBits-1:0] req_x_coord = '0;
   logic signed [CoordBits-1:0] req_y_coord = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [LabelBits-1:0]        rsp_hit_label;
   logic [1:0]                  rsp_status;

   // Predictor copy of the shape table.
   logic [2:0]           shp_kind [MaxShapes];
   logic [LabelBits-1:0] shp_label [MaxShapes];
   int                   shp_first [MaxShapes];
   int                   shp_count [MaxShapes];
   longint               pt_x [MaxPoints];
   longint               pt_y [MaxPoints];
   int                   num_shapes = 0;
   int                   num_points = 0;

   pick_result_type pending_results [$];
   int  error_count = 0;
   int  beats_sent = 0;
   bit  send_no_gaps = 1'b0;
   bit  recv_no_stalls = 1'b0;
   bit  hold_rsp = 1'b0;
   int  idle_cycles = 0;

   shape_table_hit_test_unit uut (.*);

   always #10 clock = ~clock;

   function automatic bit shape_contains(int s, longint px, longint py);
      int     base, n;
      longint ax, ay, bx, by, cx, cy;
      longint dx, dy, dx21, dy12, d, sv, tv, den, lhs, rhs;
      logic [127:0] ux, uy, rx, ry, lsum, rr;
      bit     odd;
      int     j;
      base = shp_first[s];
      n    = shp_count[s];
      ax = (base < MaxPoints) ? pt_x[base] : 0;
      ay = (base < MaxPoints) ? pt_y[base] : 0;
      bx = (base + 1 < MaxPoints) ? pt_x[base + 1] : 0;
      by = (base + 1 < MaxPoints) ? pt_y[base + 1] : 0;
      cx = (base + 2 < MaxPoints) ? pt_x[base + 2] : 0;
      cy = (base + 2 < MaxPoints) ? pt_y[base + 2] : 0;
      case (shp_kind[s])
         KindRect: begin
            if (n < 2) return 1'b0;
            return ax <= px && px < ax + bx && ay <= py && py < ay + by;
         end
         KindCircle: begin
            if (n < 2 || bx <= 0) return 1'b0;
            dx = ax - px;
            dy = ay - py;
            return dx * dx + dy * dy <= bx * bx;
         end
         KindEllipse: begin
            if (n < 2 || bx == 0 || by == 0) return 1'b0;
            dx = px - ax;
            dy = py - ay;
            ux = (dx < 0) ? -dx : dx;
            uy = (dy < 0) ? -dy : dy;
            rx = (bx < 0) ? -bx : bx;
            ry = (by < 0) ? -by : by;
            lsum = ux * ux * ry * ry + uy * uy * rx * rx;
            rr   = rx * rx * ry * ry;
            return lsum <= rr;
         end
         KindTriangle: begin
            if (n < 3) return 1'b0;
            dx   = px - cx;
            dy   = py - cy;
            dx21 = cx - bx;
            dy12 = by - cy;
            d  = dy12 * (ax - cx) + dx21 * (ay - cy);
            sv = dy12 * dx + dx21 * dy;
            tv = (cy - ay) * dx + (ax - cx) * dy;
            if (d < 0) return sv <= 0 && tv <= 0 && sv + tv >= d;
            return sv >= 0 && tv >= 0 && sv + tv <= d;
         end
         KindPolygon: begin
            if (n < 3) return 1'b0;
            odd = 1'b0;
            j = n - 1;
            for (int i = 0; i < n; i++) begin
               ax = pt_x[base + i];
               ay = pt_y[base + i];
               bx = pt_x[base + j];
               by = pt_y[base + j];
               if (((ay < py && by >= py) || (by < py && ay >= py)) &&
                   (ax <= px || bx <= px)) begin
                  den = by - ay;
                  lhs = (py - ay) * (bx - ax);
                  rhs = (px - ax) * den;
                  if (den > 0 ? lhs < rhs : lhs > rhs) odd = !odd;
               end
               j = i;
            end
            return odd;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic pick_result_type apply_request(logic [1:0] cmd, logic [2:0] kind,
         logic [LabelBits-1:0] label, logic signed [CoordBits-1:0] x,
         logic signed [CoordBits-1:0] y);
      pick_result_type r;
      r.hit_label = '0;
      r.status    = StatusOk;
      case (cmd)
         CMD_CLEAR: begin
            num_shapes = 0;
            num_points = 0;
         end
         CMD_OPEN: begin
            if (num_shapes >= MaxShapes) r.status = StatusShapesFull;
            else begin
               shp_kind[num_shapes]  = kind;
               shp_label[num_shapes] = label;
               shp_first[num_shapes] = num_points;
               shp_count[num_shapes] = 0;
               num_shapes++;
            end
         end
         CMD_APPEND: begin
            if (num_shapes == 0) r.status = StatusNoShape;
            else if (num_points >= MaxPoints) r.status = StatusPointsFull;
            else begin
               pt_x[num_points] = longint'(x);
               pt_y[num_points] = longint'(y);
               num_points++;
               shp_count[num_shapes - 1]++;
            end
         end
         default: begin
            for (int s = 0; s < num_shapes; s++) begin
               if (shape_contains(s, longint'(x), longint'(y))) begin
                  r.hit_label = shp_label[s];
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      if (send_no_gaps) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(5, 40);
   endfunction

   task automatic send_beat(logic [1:0] cmd, logic [2:0] kind, logic [LabelBits-1:0] label,
         int x, int y);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_shape_kind  <= kind;
      req_shape_label <= label;
      req_x_coord     <= CoordBits'(x);
      req_y_coord     <= CoordBits'(y);
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_request(cmd, kind, label, CoordBits'(x),
                                              CoordBits'(y)));
      beats_sent++;
   endtask

   task automatic open_shape(logic [2:0] kind, logic [LabelBits-1:0] label);
      send_beat(CMD_OPEN, kind, label, $urandom, $urandom);
   endtask

   task automatic append_point(int x, int y);
      send_beat(CMD_APPEND, 3'($urandom), $urandom, x, y);
   endtask

   task automatic pick_at(int x, int y);
      send_beat(CMD_PICK, 3'($urandom), $urandom, x, y);
   endtask

   function automatic int near(int center, int span);
      int v;
      v = center + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic test_directed_shapes();
      send_beat(CMD_CLEAR, KindRect, '0, 0, 0);
      append_point(5, 5);                                  // append with no shape
      open_shape(KindCircle, 32'h0000_0011);               // zero radius
      append_point(0, 0);
      append_point(0, 0);
      open_shape(KindEllipse, 32'h0000_0022);              // zero y radius
      append_point(0, 0);
      append_point(40, 0);
      open_shape(KindUndef, 32'h0000_0033);                // unknown kind
      append_point(0, 0);
      append_point(100, 100);
      open_shape(KindTriangle, 32'h0000_0044);             // degenerate, collinear
      append_point(-10, -10);
      append_point(0, 0);
      append_point(10, 10);
      open_shape(KindRect, 32'hffff_ffff);
      append_point(-32768, -32768);
      append_point(32767, 32767);
      pick_at(0, 0);
      pick_at(32767, 32767);
      pick_at(-32768, -32768);
      open_shape(KindEllipse, '0);                         // negative radii
      append_point(100, 100);
      append_point(-30, -20);
      pick_at(110, 105);
      send_beat(CMD_CLEAR, KindRect, '0, 0, 0);
      open_shape(KindPolygon, 32'h0000_0055);
      append_point(0, 0);
      append_point(200, 0);
      append_point(100, 200);
      pick_at(100, 50);
      pick_at(300, 50);
      open_shape(KindCircle, 32'h0000_0066);               // negative radius
      append_point(500, 500);
      append_point(-40, 0);
      pick_at(500, 500);
   endtask

   task automatic test_table_limits();
      send_beat(CMD_CLEAR, KindRect, '0, 0, 0);
      for (int i = 0; i <= MaxShapes; i++) open_shape(KindPolygon, LabelBits'(i + 1));
      for (int i = 0; i <= MaxPoints; i++) append_point(near(0, 3000), near(0, 3000));
      pick_at(0, 0);
      send_beat(CMD_CLEAR, KindRect, '0, 0, 0);
   endtask

   task automatic build_scene();
      int nshapes, cx, cy, span, npts;
      logic [2:0] kind;
      int px [MaxShapes];
      int py [MaxShapes];
      send_beat(CMD_CLEAR, 3'($urandom), $urandom, $urandom, $urandom);
      nshapes = $urandom_range(1, 6);
      span = ($urandom_range(0, 9) == 0) ? 32767 : 2000;
      for (int s = 0; s < nshapes; s++) begin
         kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
         open_shape(kind, ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom);
         cx = near(0, span);
         cy = near(0, span);
         px[s] = cx;
         py[s] = cy;
         case (kind)
            KindTriangle: npts = 3;
            KindPolygon:  npts = $urandom_range(3, 8);
            default:      npts = 2;
         endcase
         if ($urandom_range(0, 9) == 0) npts = npts + int'($urandom_range(0, 2)) - 1;
         for (int p = 0; p < npts; p++) begin
            if (p == 0 || kind == KindTriangle || kind == KindPolygon)
               append_point(near(cx, 300), near(cy, 300));
            else if (kind == KindRect) append_point(near(200, 250), near(200, 250));
            else append_point(near(100, 300), near(100, 300));
         end
      end
      repeat ($urandom_range(3, 10)) begin
         cx = $urandom_range(0, nshapes - 1);
         pick_at(near(px[cx], 350), near(py[cx], 350));
      end
   endtask

   task automatic test_random_scenes();
      while (beats_sent < 1650) begin
         send_no_gaps   = ($urandom_range(0, 4) == 0);
         recv_no_stalls = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               send_beat(2'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
         end else build_scene();
      end
      send_no_gaps   = 1'b0;
      recv_no_stalls = 1'b0;
   endtask

   task automatic test_backpressure();
      send_no_gaps = 1'b1;
      hold_rsp = 1'b1;
      build_scene();
      repeat (20) pick_at(near(0, 2000), near(0, 2000));
      send_no_gaps = 1'b0;
   endtask

   // Result channel ready, with random stalls and one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            if (!recv_no_stalls && $urandom_range(0, 9) < 3)
               stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 60);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      pick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no request outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit_label !== want.hit_label) begin
               $error("hit_label expected %h actual %h", want.hit_label, rsp_hit_label);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles + 1 >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_shapes();
      test_table_limits();
      test_backpressure();
      test_random_scenes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
